// ===== rtl/fed_pkg.sv =====
// shared types, character codes and byte mapping functions for the filename escape decoder
package fed_pkg;

  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TILDE      = 8'h7E;
  localparam logic [7:0] CH_APOSTROPHE = 8'h27;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CODE_QUOTE    = 8'h01;
  localparam logic [7:0] CODE_SLASH    = 8'h02;
  localparam logic [7:0] CODE_COLON    = 8'h03;
  localparam logic [4:0] HEX_NONE      = 5'd16;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } dec_t;

  function automatic logic [7:0] map_byte(input logic [7:0] c);
    logic [7:0] m;
    unique case (c)
      CH_UNDERSCORE: m = CH_SPACE;
      CH_SLASH:      m = CH_TILDE;
      CODE_QUOTE:    m = CH_APOSTROPHE;
      CODE_SLASH:    m = CH_SLASH;
      CODE_COLON:    m = CH_COLON;
      default:       m = c;
    endcase
    return m;
  endfunction

  // digit value 0..15, HEX_NONE when not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_NONE;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h61 + 8'd10);
    end
    return v;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] parse_pair(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] ha;
    logic [4:0] hb;
    logic [7:0] v;
    ha = hex_val(a);
    hb = hex_val(b);
    v  = 8'h00;
    if (!ha[4]) begin
      v = hb[4] ? {4'h0, ha[3:0]} : {ha[3:0], hb[3:0]};
    end else if (hb[4]) begin
      v = 8'h00;
    end else if (is_space(a) || a == CH_PLUS) begin
      v = {4'h0, hb[3:0]};
    end else if (a == CH_MINUS) begin
      v = 8'h00 - {4'h0, hb[3:0]};
    end
    return v;
  endfunction

endpackage

// ===== rtl/fed_decode.sv =====
// escape state machine: turns one byte into zero, one or two result bytes
module fed_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      byte_in,
  input  logic            is_final,
  output fed_pkg::dec_t   dec
);

  localparam logic [1:0] STAGE_IDLE  = 2'd0;
  localparam logic [1:0] STAGE_HASH  = 2'd1;
  localparam logic [1:0] STAGE_DIGIT = 2'd2;

  logic [1:0] stage;
  logic [1:0] stage_next;
  logic [7:0] first_char;
  logic [7:0] first_char_next;

  always_comb begin
    stage_next      = STAGE_IDLE;
    first_char_next = first_char;
    dec.count       = 2'd0;
    dec.r0          = '{data: fed_pkg::map_byte(byte_in), last: is_final};
    dec.r1          = '{data: fed_pkg::map_byte(byte_in), last: 1'b1};
    unique case (stage)
      STAGE_HASH: begin
        if (is_final) begin
          dec.count = 2'd2;
          dec.r0    = '{data: fed_pkg::CH_HASH, last: 1'b0};
        end else begin
          first_char_next = byte_in;
          stage_next      = STAGE_DIGIT;
        end
      end
      STAGE_DIGIT: begin
        dec.count = 2'd1;
        dec.r0    = '{data: fed_pkg::parse_pair(first_char, byte_in), last: is_final};
      end
      default: begin
        if (byte_in == fed_pkg::CH_HASH && !is_final) begin
          stage_next = STAGE_HASH;
        end else begin
          dec.count = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage      <= STAGE_IDLE;
      first_char <= 8'h00;
    end else if (step) begin
      stage      <= stage_next;
      first_char <= first_char_next;
    end
  end

endmodule

// ===== rtl/fed_outq.sv =====
// two-entry result queue feeding the output stream
module fed_outq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fed_pkg::dec_t   dec,
  output logic [1:0]      free,
  output logic            out_valid,
  input  logic            out_ready,
  output fed_pkg::result_t out_res
);

  fed_pkg::result_t q [fed_pkg::QUEUE_DEPTH];
  fed_pkg::result_t q_next [fed_pkg::QUEUE_DEPTH];
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;
  logic [1:0] kept;

  assign out_valid = (count != 2'd0);
  assign out_res   = q[0];
  assign pop       = out_valid && out_ready;
  assign kept      = count - {1'b0, pop};
  assign free      = 2'(fed_pkg::QUEUE_DEPTH) - kept;

  always_comb begin
    if (pop) begin
      q_next[0] = q[1];
    end else begin
      q_next[0] = q[0];
    end
    q_next[1]  = q[1];
    count_next = kept;
    if (push) begin
      count_next = kept + dec.count;
      case (kept)
        2'd0: begin
          q_next[0] = dec.r0;
          q_next[1] = dec.r1;
        end
        2'd1: begin
          q_next[1] = dec.r0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    q[0] <= q_next[0];
    q[1] <= q_next[1];
  end

endmodule

// ===== rtl/filename_escape_decoder.sv =====
// top level: input register, escape decode and two-entry output queue
// path: an accepted request goes through the input register, then is decoded into the output queue
// throughput: one byte per cycle while the output queue has room; a short escape ending
//   the name yields two results and holds the input register until both fit in the queue
// reset (rst, synchronous): clears escape state, input valid flag and queue count
module filename_escape_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] byte_in
  input  logic       s_tlast,   // is_final
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] byte_out
  output logic       m_tlast    // end_of_name
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             in_last;
  logic             consume;
  logic [1:0]       free;
  fed_pkg::dec_t    dec;
  fed_pkg::result_t out_res;

  assign consume  = in_valid && (dec.count <= free);
  assign s_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  fed_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .step     (consume),
    .byte_in  (in_byte),
    .is_final (in_last),
    .dec      (dec)
  );

  fed_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (consume),
    .dec       (dec),
    .free      (free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = out_res.data;
  assign m_tlast = out_res.last;

endmodule

// ===== bench/filename_escape_decoder_tb.sv =====
// testbench for the filename escape decoder: directed and random names checked against a predictor
`timescale 1ns / 1ps

module filename_escape_decoder_tb;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 12;
  localparam int QUIET_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 8;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASE_ITEMS  = 160;

  localparam logic [1:0] STAGE_IDLE  = 2'd0;
  localparam logic [1:0] STAGE_HASH  = 2'd1;
  localparam logic [1:0] STAGE_DIGIT = 2'd2;

  localparam logic [7:0] WS_LOW  = 8'h09;
  localparam logic [7:0] WS_HIGH = 8'h0D;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } decoded_t;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;

  decoded_t   decoded_q[$];
  logic [1:0] dec_stage;
  logic [7:0] held_digit;

  int gap_pct;
  int stall_pct;
  int mismatches;
  int requests_sent;
  int results_checked;
  int names_sent;
  int escapes_sent;
  int quiet_cycles;

  filename_escape_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] byte_in
    .s_tlast  (s_tlast),   // is_final
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [7:0] byte_out
    .m_tlast  (m_tlast)    // end_of_name
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic [7:0] remap_char(input logic [7:0] c);
    case (c)
      fed_pkg::CH_UNDERSCORE: return fed_pkg::CH_SPACE;
      fed_pkg::CH_SLASH:      return fed_pkg::CH_TILDE;
      fed_pkg::CODE_QUOTE:    return fed_pkg::CH_APOSTROPHE;
      fed_pkg::CODE_SLASH:    return fed_pkg::CH_SLASH;
      fed_pkg::CODE_COLON:    return fed_pkg::CH_COLON;
      default:                return c;
    endcase
  endfunction

  // -1 when c is not a hex digit
  function automatic int digit_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] pair_value(input logic [7:0] a, input logic [7:0] b);
    int da;
    int db;
    da = digit_of(a);
    db = digit_of(b);
    if (da >= 0) return (db >= 0) ? 8'(da * 16 + db) : 8'(da);
    if (db < 0) return 8'h00;
    if (a == fed_pkg::CH_SPACE || (a >= WS_LOW && a <= WS_HIGH) || a == fed_pkg::CH_PLUS)
      return 8'(db);
    if (a == fed_pkg::CH_MINUS) return 8'(256 - db);
    return 8'h00;
  endfunction

  function automatic void decode_request(input logic [7:0] c, input logic fin);
    case (dec_stage)
      STAGE_HASH: begin
        if (fin) begin
          decoded_q.push_back('{data: fed_pkg::CH_HASH, last: 1'b0});
          decoded_q.push_back('{data: remap_char(c), last: 1'b1});
          dec_stage = STAGE_IDLE;
        end else begin
          held_digit = c;
          dec_stage  = STAGE_DIGIT;
        end
      end
      STAGE_DIGIT: begin
        decoded_q.push_back('{data: pair_value(held_digit, c), last: fin});
        dec_stage = STAGE_IDLE;
      end
      default: begin
        dec_stage = STAGE_IDLE;
        if (c == fed_pkg::CH_HASH && !fin) begin
          dec_stage = STAGE_HASH;
        end else begin
          decoded_q.push_back('{data: remap_char(c), last: fin});
        end
      end
    endcase
  endfunction

  task automatic send_request(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= fin;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    decode_request(c, fin);
    requests_sent++;
    if (c == fed_pkg::CH_HASH) escapes_sent++;
    if (fin) names_sent++;
  endtask

  task automatic send_name(input logic [7:0] chars[$]);
    foreach (chars[i]) send_request(chars[i], i == chars.size() - 1);
  endtask

  // sender holds off until every outstanding result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_byte_mapping();
    send_name('{8'h00, 8'hFF, fed_pkg::CH_UNDERSCORE, fed_pkg::CH_SLASH, fed_pkg::CODE_QUOTE,
                fed_pkg::CODE_SLASH, fed_pkg::CODE_COLON});
  endtask

  task automatic test_hex_escapes();
    // decoded byte is not remapped
    send_name('{fed_pkg::CH_HASH, "5", "F"});
    // minus sign wraps to 0xff
    send_name('{fed_pkg::CH_HASH, fed_pkg::CH_MINUS, "1"});
    // leading whitespace skipped
    send_name('{fed_pkg::CH_HASH, WS_HIGH, "9"});
    // digit then non-digit, and a zero byte out
    send_name('{fed_pkg::CH_HASH, "0", "x"});
  endtask

  task automatic test_short_escapes();
    send_name('{fed_pkg::CH_HASH});
    send_name('{fed_pkg::CH_HASH, fed_pkg::CH_UNDERSCORE});
  endtask

  function automatic logic [7:0] pick_digit_char();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 8'("0" + $urandom_range(9));
    if (r < 38) return 8'("a" + $urandom_range(5));
    if (r < 50) return 8'("A" + $urandom_range(5));
    if (r < 58) return fed_pkg::CH_SPACE;
    if (r < 64) return 8'($urandom_range(WS_HIGH, WS_LOW));
    if (r < 70) return fed_pkg::CH_PLUS;
    if (r < 76) return fed_pkg::CH_MINUS;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_plain_char();
    logic [7:0] specials[8];
    specials = '{fed_pkg::CH_UNDERSCORE, fed_pkg::CH_SLASH, fed_pkg::CODE_QUOTE,
                 fed_pkg::CODE_SLASH, fed_pkg::CODE_COLON, fed_pkg::CH_HASH, 8'h00, 8'hFF};
    if ($urandom_range(99) < 35) return specials[$urandom_range(7)];
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random_name();
    logic [7:0] chars[$];
    int         len;
    len = $urandom_range(12, 1);
    while (chars.size() < len) begin
      if ($urandom_range(99) < 35) begin
        chars.push_back(fed_pkg::CH_HASH);
        chars.push_back(pick_digit_char());
        chars.push_back(pick_digit_char());
      end else begin
        chars.push_back(pick_plain_char());
      end
    end
    // cutting at len leaves some escapes short at the end of the name
    while (chars.size() > len) void'(chars.pop_back());
    send_name(chars);
  endtask

  task automatic run_random_phase(input int gap, input int stall);
    int start;
    gap_pct   = gap;
    stall_pct = stall;
    start     = requests_sent;
    while (requests_sent - start < PHASE_ITEMS) send_random_name();
    drain_results();
  endtask

  task automatic test_random_names();
    run_random_phase(0, 0);
    run_random_phase(67, 0);
    run_random_phase(0, 67);
    run_random_phase(18, 18);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    decoded_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      results_checked++;
      if (decoded_q.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected result: data %02h last %b", m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (m_tdata !== want.data || m_tlast !== want.last) begin
          if (mismatches < REPORT_LIMIT)
            $display("mismatch: expected data %02h last %b, got data %02h last %b",
                     want.data, want.last, m_tdata, m_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
      $display("** filename_escape_decoder: FAILED **");
      $finish;
    end
  end

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'h00;
    s_tlast   <= 1'b0;
    gap_pct         = 0;
    stall_pct       = 0;
    requests_sent   = 0;
    names_sent      = 0;
    escapes_sent    = 0;
    dec_stage       = STAGE_IDLE;
    held_digit      = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_byte_mapping();
    test_hex_escapes();
    test_short_escapes();
    drain_results();
    test_random_names();

    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests in %0d names with %0d hash bytes, %0d results checked",
             requests_sent, names_sent, escapes_sent, results_checked);
    $display("idle mixes: none, sender gaps, receiver stalls, both; %0d mismatches",
             mismatches);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("** filename_escape_decoder: PASSED **");
    end else begin
      $display("** filename_escape_decoder: FAILED **");
    end
    $finish;
  end

endmodule
